FILE: design/key_matrix_debounce_unit_assert.svh
// Assertion macros shared by the key matrix debounce design.
// Both forms sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef KEY_MATRIX_DEBOUNCE_UNIT_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KMD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key matrix debounce check failed");
`define KMD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key matrix debounce check failed");
`else
`define KMD_ASSERT_SAME(label, ante, cons)
`define KMD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/kmd_pkg.sv
package kmd_pkg;

	localparam int DRV_W = 4;
	localparam int SNS_W = 4;
	localparam int LEVEL_W = 16;
	localparam int CNT_W = 16;
	localparam int SLU_W = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 16'd1;
	localparam logic [SLU_W-1:0] LANES_RESET = 5'd16;

	typedef enum logic {
		REG_DEBOUNCE = 1'b0,
		REG_LANES = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic seed;
		logic hit;
		logic row_vld;
		logic [CNT_W-1:0] thr;
	} lane_ctrl_t;

	typedef struct packed {
		logic pressed;
		logic [CNT_W-1:0] count;
	} cell_t;

endpackage

FILE: design/kmd_lane.sv
module kmd_lane #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic clk,
	input  kmd_pkg::lane_ctrl_t ctrl,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	input  logic lane_on,
	input  logic level,
	output logic evt,
	output logic new_pressed
);
	import kmd_pkg::*;

	cell_t mem [DEPTH];
	cell_t entry_s1;
	cell_t fwd_q;
	cell_t cur;
	cell_t nxt;
	logic raw;
	logic [CNT_W-1:0] inc;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= nxt;
		end
		if (ctrl.rd_en) begin
			entry_s1 <= mem[rd_addr];
			fwd_q <= nxt;
		end
	end

	always_comb begin
		if (ctrl.hit) begin
			cur = fwd_q;
		end else if (ctrl.row_vld) begin
			cur = entry_s1;
		end else begin
			cur = '0;
		end
		raw = ~level;
		inc = (cur.count == CNT_MAX) ? cur.count : cur.count + 1'b1;
		nxt = cur;
		evt = 1'b0;
		if (lane_on) begin
			if (ctrl.seed) begin
				nxt.pressed = raw;
			end else if (raw == cur.pressed) begin
				nxt.count = '0;
			end else if (inc >= ctrl.thr) begin
				nxt.pressed = raw;
				nxt.count = '0;
				evt = 1'b1;
			end else begin
				nxt.count = inc;
			end
		end
		new_pressed = nxt.pressed;
	end

endmodule

FILE: design/kmd_drain.sv
module kmd_drain #(
	parameter int LANES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic [LANES-1:0] mask,
	input  logic [LANES-1:0] pressed,
	input  logic [kmd_pkg::DRV_W-1:0] drive,
	output logic can_load,
	output logic out_valid,
	input  logic out_ready,
	output logic [kmd_pkg::DRV_W-1:0] event_drive,
	output logic [kmd_pkg::SNS_W-1:0] event_sense,
	output logic now_pressed,
	output logic last_event
);
	import kmd_pkg::*;

	logic vld_q;
	logic [LANES-1:0] mask_q;
	logic [LANES-1:0] pressed_q;
	logic [DRV_W-1:0] drive_q;
	logic [LANES-1:0] low_bit;
	logic [LANES-1:0] rest;
	logic [SNS_W-1:0] idx;
	logic taken;

	always_comb begin
		low_bit = mask_q & (~mask_q + 1'b1);
		rest = mask_q & ~low_bit;
		idx = '0;
		for (int i = 0; i < LANES; i++) begin
			if (low_bit[i]) begin
				idx = idx | SNS_W'(i);
			end
		end
	end

	assign taken = vld_q && out_ready;
	assign can_load = !vld_q || (taken && (rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load && can_load) begin
			vld_q <= 1'b1;
		end else if (taken) begin
			vld_q <= (rest != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			mask_q <= mask;
			pressed_q <= pressed;
			drive_q <= drive;
		end else if (taken) begin
			mask_q <= rest;
		end
	end

	assign out_valid = vld_q;
	assign event_drive = drive_q;
	assign event_sense = idx;
	assign now_pressed = |(pressed_q & low_bit);
	assign last_event = (rest == '0);

endmodule

FILE: design/key_matrix_debounce_unit.sv
// Key matrix debouncer: each input transaction carries one drive line's index and the
// active-low levels of its sense lines; every key keeps a debounced pressed bit and a
// disagree counter, and a flip leaves as one output transaction, lowest sense line first,
// the final one of a row marked by last_event. A row that raises no event never waits in the
// compute stage. A row that raises k events holds the output register for k accepted output
// transactions, one event each, and a following row that raises events waits in the compute
// stage until the last of them is taken. A new row is therefore taken every cycle while each
// row raises at most one event and the output is not stalled. The first event of a row passes
// the compute stage and is registered in the output register when that register is free.
// Each sense lane has its own key state memory of MAX_DRIVE entries with one read and one
// write port, read when a row is accepted and written back when the row leaves the compute
// stage, with forwarding between successive rows.
// State after reset is all released with cleared counters, tracked by one valid bit per
// drive line, so no clearing pass is needed. Seed transactions overwrite a row's pressed bits
// without events, and drive indexes at or above MAX_DRIVE are accepted and ignored.
`include "key_matrix_debounce_unit_assert.svh"
module key_matrix_debounce_unit #(
	parameter int MAX_DRIVE = 16,
	parameter int MAX_SENSE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [kmd_pkg::PADDR_W-1:0] paddr,
	input  logic [kmd_pkg::PDATA_W-1:0] pwdata,
	output logic [kmd_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [kmd_pkg::DRV_W-1:0] drive_index,
	input  logic [kmd_pkg::LEVEL_W-1:0] sense_levels,
	input  logic seed,
	output logic out_valid,
	input  logic out_ready,
	output logic [kmd_pkg::DRV_W-1:0] event_drive,
	output logic [kmd_pkg::SNS_W-1:0] event_sense,
	output logic now_pressed,
	output logic last_event
);
	import kmd_pkg::*;

	localparam int LANES = (MAX_SENSE < 16) ? MAX_SENSE : 16;
	localparam int AW = (MAX_DRIVE > 1) ? $clog2(MAX_DRIVE) : 1;

	logic [CNT_W-1:0] debounce_q;
	logic [SLU_W-1:0] lanes_q;
	logic cfg_wr;
	reg_idx_t cfg_idx;

	logic [MAX_DRIVE-1:0] row_vld_q;
	logic s1_vld_q;
	logic [DRV_W-1:0] drive_s1;
	logic [LEVEL_W-1:0] levels_s1;
	logic seed_s1;
	logic hit_s1;
	logic rowv_s1;
	logic [AW-1:0] addr_s1;

	logic acc;
	logic in_range;
	logic [AW+DRV_W-1:0] addr_ext;
	logic [AW-1:0] in_addr;
	logic s1_adv;
	logic drain_ok;
	logic [LANES-1:0] evt;
	logic [LANES-1:0] prs;
	lane_ctrl_t ctrl;

	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		case (cfg_idx)
			REG_DEBOUNCE: prdata = PDATA_W'(debounce_q);
			REG_LANES: prdata = PDATA_W'(lanes_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			lanes_q <= LANES_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DEBOUNCE: debounce_q <= pwdata[CNT_W-1:0];
				REG_LANES: lanes_q <= pwdata[SLU_W-1:0];
				default: ;
			endcase
		end
	end

	assign addr_ext = {{AW{1'b0}}, drive_index};
	assign in_addr = addr_ext[AW-1:0];
	assign in_range = 32'(drive_index) < MAX_DRIVE;

	assign s1_adv = s1_vld_q && ((evt == '0) || drain_ok);
	assign in_ready = !s1_vld_q || s1_adv;
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			row_vld_q <= '0;
		end else begin
			if (in_ready) begin
				s1_vld_q <= acc && in_range;
			end
			if (s1_adv) begin
				row_vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			drive_s1 <= drive_index;
			levels_s1 <= sense_levels;
			seed_s1 <= seed;
			addr_s1 <= in_addr;
			rowv_s1 <= row_vld_q[in_addr];
			hit_s1 <= s1_adv && (addr_s1 == in_addr);
		end
	end

	always_comb begin
		ctrl.rd_en = acc;
		ctrl.wr_en = s1_adv;
		ctrl.seed = seed_s1;
		ctrl.hit = hit_s1;
		ctrl.row_vld = rowv_s1;
		ctrl.thr = (debounce_q == '0) ? CNT_W'(1) : debounce_q;
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		kmd_lane #(
			.DEPTH(MAX_DRIVE),
			.AW(AW)
		) u_lane (
			.clk(clk),
			.ctrl(ctrl),
			.rd_addr(in_addr),
			.wr_addr(addr_s1),
			.lane_on(SLU_W'(l) < lanes_q),
			.level(levels_s1[l]),
			.evt(evt[l]),
			.new_pressed(prs[l])
		);
	end

	kmd_drain #(
		.LANES(LANES)
	) u_drain (
		.clk(clk),
		.arst_n(arst_n),
		.load(s1_vld_q && (evt != '0)),
		.mask(evt),
		.pressed(prs),
		.drive(drive_s1),
		.can_load(drain_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_drive(event_drive),
		.event_sense(event_sense),
		.now_pressed(now_pressed),
		.last_event(last_event)
	);

	`KMD_ASSERT_NEXT(a_row_drains_on, out_valid && out_ready && !last_event, out_valid)
	`KMD_ASSERT_NEXT(a_events_reach_output, s1_adv && (evt != '0), out_valid)
	`KMD_ASSERT_SAME(a_event_drive_in_range, out_valid, 32'(event_drive) < MAX_DRIVE)

endmodule

FILE: verif/tb_top.sv
module tb_top;
	import kmd_pkg::*;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		reg_idx_t reg_sel;
		logic [31:0] value;
		logic [3:0] drive;
		logic seed;
		logic typed;
		logic [15:0] exp_mask;
		logic exp_press;
	} dir_row_t;

	typedef struct packed {
		logic [3:0] drv;
		logic [3:0] sns;
		logic pressed;
		logic last;
	} key_flip_t;

	localparam int N_DRIVE = 16;
	localparam int N_SENSE = 16;
	localparam int N_DIR = 31;
	localparam int N_PHASE = 6;
	localparam logic [15:0] PH_THR [N_PHASE] = '{16'd1, 16'd2, 16'd4, 16'd3, 16'hFFFF, 16'd2};
	localparam logic [4:0] PH_LANES [N_PHASE] = '{5'd16, 5'd16, 5'd9, 5'd1, 5'd16, 5'd13};
	localparam int PH_ITEMS [N_PHASE] = '{35, 35, 35, 35, 20, 35};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [DRV_W-1:0] drive_index = '0;
	logic [LEVEL_W-1:0] sense_levels = '1;
	logic seed = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DRV_W-1:0] event_drive;
	logic [SNS_W-1:0] event_sense;
	logic now_pressed;
	logic last_event;

	logic key_pressed [N_DRIVE][N_SENSE];
	logic [CNT_W-1:0] key_count [N_DRIVE][N_SENSE];
	logic [CNT_W-1:0] cfg_thr = DEBOUNCE_RESET;
	logic [SLU_W-1:0] cfg_lanes = LANES_RESET;
	key_flip_t flip_queue [$];
	dir_row_t dir_rows [N_DIR];
	logic [15:0] row_target [N_DRIVE];

	int mismatch_cnt = 0;
	bit steady = 1'b0;
	int stall_asks = 0;
	int stall_taken = 0;
	int hold_left = 0;

	key_matrix_debounce_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.drive_index(drive_index),
		.sense_levels(sense_levels),
		.seed(seed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_drive(event_drive),
		.event_sense(event_sense),
		.now_pressed(now_pressed),
		.last_event(last_event)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic dir_row_t row_item(input logic [3:0] d, input logic [15:0] lv,
			input logic sd, input logic typed, input logic [15:0] mask, input logic pr);
		dir_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.drive = d;
		r.value = {16'h0, lv};
		r.seed = sd;
		r.typed = typed;
		r.exp_mask = mask;
		r.exp_press = pr;
		return r;
	endfunction

	function automatic dir_row_t row_cfg(input reg_idx_t idx, input logic [31:0] val);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.reg_sel = idx;
		r.value = val;
		return r;
	endfunction

	task automatic debounce_row(input logic [3:0] d, input logic [15:0] lv, input logic sd,
			output logic [15:0] fmask, output logic [15:0] fpress);
		int lanes;
		logic raw;
		fmask = '0;
		fpress = '0;
		lanes = (cfg_lanes > 5'd16) ? 16 : int'(cfg_lanes);
		for (int s = 0; s < lanes; s++) begin
			raw = ~lv[s];
			if (sd) begin
				key_pressed[d][s] = raw;
			end else if (raw == key_pressed[d][s]) begin
				key_count[d][s] = '0;
			end else begin
				if (key_count[d][s] != CNT_MAX)
					key_count[d][s] = key_count[d][s] + 1'b1;
				if (key_count[d][s] >= cfg_thr) begin
					key_pressed[d][s] = raw;
					key_count[d][s] = '0;
					fmask[s] = 1'b1;
					fpress[s] = raw;
				end
			end
		end
	endtask

	task automatic queue_flips(input logic [3:0] d, input logic [15:0] mask,
			input logic [15:0] pbits);
		int top;
		top = -1;
		for (int s = 0; s < 16; s++)
			if (mask[s])
				top = s;
		for (int s = 0; s < 16; s++)
			if (mask[s])
				flip_queue.push_back('{drv: d, sns: 4'(s), pressed: pbits[s], last: (s == top)});
	endtask

	task automatic send_row(input logic [3:0] d, input logic [15:0] lv, input logic sd,
			input logic typed, input logic [15:0] tmask, input logic tpress);
		logic [15:0] fm;
		logic [15:0] fp;
		if (!steady && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		drive_index <= d;
		sense_levels <= lv;
		seed <= sd;
		do @(posedge clk); while (!in_ready);
		debounce_row(d, lv, sd, fm, fp);
		if (typed)
			queue_flips(d, tmask, {16{tpress}});
		else
			queue_flips(d, fm, fp);
	endtask

	task automatic drain_events();
		in_valid <= 1'b0;
		while (flip_queue.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(int'(idx) * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_DEBOUNCE)
			cfg_thr = val[CNT_W-1:0];
		else
			cfg_lanes = val[SLU_W-1:0];
	endtask

	always @(posedge clk) begin
		if (stall_asks != stall_taken) begin
			stall_taken = stall_asks;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 9);
		end
	end

	always @(posedge clk) begin
		key_flip_t want;
		if (arst_n && out_valid && out_ready) begin
			if (flip_queue.size() == 0) begin
				if (mismatch_cnt < 10)
					$display("unexpected transaction: drive %0d sense %0d pressed %0d last %0d",
						event_drive, event_sense, now_pressed, last_event);
				mismatch_cnt++;
			end else begin
				want = flip_queue.pop_front();
				if (event_drive !== want.drv || event_sense !== want.sns ||
						now_pressed !== want.pressed || last_event !== want.last) begin
					if (mismatch_cnt < 10)
						$display("mismatch: expected d%0d s%0d p%0d l%0d, got d%0d s%0d p%0d l%0d",
							want.drv, want.sns, want.pressed, want.last,
							event_drive, event_sense, now_pressed, last_event);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		#400000;
		$display("** key_matrix_debounce_unit: FAILED **");
		$finish;
	end

	initial begin
		logic [3:0] d;
		logic [15:0] lv;
		logic sd;
		for (int i = 0; i < N_DRIVE; i++) begin
			row_target[i] = '1;
			for (int s = 0; s < N_SENSE; s++) begin
				key_pressed[i][s] = 1'b0;
				key_count[i][s] = '0;
			end
		end
		dir_rows = '{
			row_item(4'd0, 16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b1),
			row_item(4'd0, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0),
			row_item(4'd15, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0),
			row_item(4'd15, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0),
			row_item(4'd15, 16'h5555, 1'b0, 1'b1, 16'hAAAA, 1'b1),
			row_item(4'd7, 16'h7FFF, 1'b0, 1'b1, 16'h8000, 1'b1),
			row_cfg(REG_LANES, 32'd0),
			row_item(4'd3, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0),
			row_cfg(REG_LANES, 32'd31),
			row_item(4'd3, 16'hFFFE, 1'b0, 1'b1, 16'h0001, 1'b1),
			row_cfg(REG_LANES, 32'd4),
			row_item(4'd3, 16'h0000, 1'b0, 1'b1, 16'h000E, 1'b1),
			row_item(4'd3, 16'hFFFF, 1'b0, 1'b1, 16'h000F, 1'b0),
			row_cfg(REG_DEBOUNCE, 32'd0),
			row_item(4'd4, 16'hFFF0, 1'b0, 1'b1, 16'h000F, 1'b1),
			row_cfg(REG_DEBOUNCE, 32'd3),
			row_cfg(REG_LANES, 32'd16),
			row_item(4'd5, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0),
			row_item(4'd5, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0),
			row_item(4'd5, 16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b1),
			row_item(4'd5, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0),
			row_item(4'd5, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0),
			row_item(4'd5, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0),
			row_item(4'd5, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0),
			row_cfg(REG_DEBOUNCE, 32'hFFFF),
			row_item(4'd6, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0),
			row_item(4'd6, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0),
			row_cfg(REG_DEBOUNCE, 32'd1),
			row_item(4'd6, 16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b1),
			row_item(4'd9, 16'hA5C3, 1'b1, 1'b0, 16'h0000, 1'b0),
			row_item(4'd5, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain_events();
				reg_write(dir_rows[i].reg_sel, dir_rows[i].value);
			end else begin
				send_row(dir_rows[i].drive, dir_rows[i].value[15:0], dir_rows[i].seed,
					dir_rows[i].typed, dir_rows[i].exp_mask, dir_rows[i].exp_press);
			end
		end

		for (int p = 0; p < N_PHASE; p++) begin
			drain_events();
			steady = (p == 1);
			reg_write(REG_DEBOUNCE, {16'h0, PH_THR[p]});
			reg_write(REG_LANES, {27'h0, PH_LANES[p]});
			for (int n = 0; n < PH_ITEMS[p]; n++) begin
				if (p == 0 && n == 20)
					stall_asks++;
				if (p == 2 && n == 20)
					drain_events();
				if ($urandom_range(99) < 10) begin
					d = 4'($urandom_range(15));
					lv = 16'($urandom);
					sd = 1'($urandom_range(1));
				end else begin
					d = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
					if ($urandom_range(99) < 15) begin
						case ($urandom_range(2))
							0: row_target[d] = '1;
							1: row_target[d] = '0;
							default: row_target[d] = 16'($urandom);
						endcase
					end
					lv = row_target[d];
					if ($urandom_range(99) < 20)
						lv[$urandom_range(15)] ^= 1'b1;
					sd = ($urandom_range(99) < 5);
				end
				send_row(d, lv, sd, 1'b0, 16'h0000, 1'b0);
			end
		end

		steady = 1'b0;
		drain_events();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0 && flip_queue.size() == 0)
			$display("** key_matrix_debounce_unit: PASSED **");
		else
			$display("** key_matrix_debounce_unit: FAILED **");
		$finish;
	end

endmodule
